// ----- src/mfq_pkg.sv -----
// Package for the multilevel FIFO queue: request and status codes,
// controller states and the command group from controller to datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mfq_pkg;

    typedef enum logic [1:0] {
        REQ_ENQ  = 2'd0,
        REQ_DEQ  = 2'd1,
        REQ_PRIO = 2'd2,
        REQ_QRY  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADIDX = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_DONE = 2'd2
    } state_t;

    typedef struct packed {
        logic latch;
        logic exec;
    } cmd_t;

    localparam logic [15:0] NO_TIME = 16'hFFFF;
    localparam logic [15:0] NO_PID  = 16'h0000;

endpackage

`default_nettype wire

// ----- src/mfq_ctrl.sv -----
// Controller of the multilevel FIFO queue: request sequencing FSM.
// Depends on mfq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfq_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output mfq_pkg::cmd_t      cmd,
    output logic               busy,
    output logic               done
);

    mfq_pkg::state_t state_reg;
    mfq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mfq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mfq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = mfq_pkg::S_EXEC;
                end
            end
            mfq_pkg::S_EXEC:
            begin
                state_next = mfq_pkg::S_DONE;
            end
            mfq_pkg::S_DONE:
            begin
                state_next = start ? mfq_pkg::S_EXEC : mfq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mfq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy      = 1'b0;
        done      = 1'b0;
        cmd.exec  = 1'b0;
        case (state_reg)
            mfq_pkg::S_EXEC:
            begin
                busy     = 1'b1;
                cmd.exec = 1'b1;
            end
            mfq_pkg::S_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
        cmd.latch = start && !busy;
    end

endmodule

`default_nettype wire

// ----- src/mfq_dp.sv -----
// Datapath of the multilevel FIFO queue: entry memory, per-queue pointers
// and counts, priority select and result registers. Depends on mfq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfq_dp #(
    parameter int NUM_QUEUES  = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mfq_pkg::cmd_t      cmd,
    input  wire logic [1:0]         req_type,
    input  wire logic [1:0]         queue_index,
    input  wire logic [15:0]        pid,
    input  wire logic signed [15:0] exec_time,
    input  wire logic               active_queues_we,
    input  wire logic [2:0]         active_queues,
    output logic [1:0]              status,
    output logic [15:0]             out_pid,
    output logic signed [15:0]      out_time,
    output logic [1:0]              served_queue,
    output logic                    queue_empty,
    output logic                    all_empty
);

    localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW  = $clog2(QUEUE_DEPTH);
    localparam int OW  = $clog2(QUEUE_DEPTH + 1);
    localparam int NW  = $clog2(NUM_QUEUES + 1);
    localparam int AW  = QW + PW;
    localparam int MEM = 1 << AW;

    logic [2:0]      active_reg;
    logic [1:0]      req_reg;
    logic [1:0]      qidx_reg;
    logic [15:0]     pid_reg;
    logic [15:0]     time_reg;

    logic [PW-1:0]   head_reg [NUM_QUEUES];
    logic [PW-1:0]   tail_reg [NUM_QUEUES];
    logic [OW-1:0]   occ_reg  [NUM_QUEUES];
    logic [OW-1:0]   occ_next [NUM_QUEUES];

    logic [31:0]     mem [MEM];
    logic [31:0]     rdata_reg;

    logic [1:0]      status_reg;
    logic [1:0]      served_reg;
    logic            qempty_reg;
    logic            allempty_reg;
    logic            pop_reg;

    logic [NW-1:0]   active_n;
    logic            valid_idx;
    logic            found;
    logic [QW-1:0]   prio_q;
    logic [QW-1:0]   target;
    logic [OW-1:0]   occ_t;
    logic [PW-1:0]   head_t;
    logic [PW-1:0]   tail_t;
    logic            do_push;
    logic            do_pop;
    logic [1:0]      status_c;
    logic            qempty_c;
    logic            allempty_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 3'd4;
        end
        else if (active_queues_we)
        begin
            active_reg <= active_queues;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg  <= req_type;
            qidx_reg <= queue_index;
            pid_reg  <= pid;
            time_reg <= $unsigned(exec_time);
        end
    end

    always_comb
    begin
        if (32'(active_reg) > NUM_QUEUES)
        begin
            active_n = NW'(NUM_QUEUES);
        end
        else
        begin
            active_n = NW'(active_reg);
        end
        valid_idx = 32'(qidx_reg) < NUM_QUEUES;

        found  = 1'b0;
        prio_q = '0;
        for (int q = NUM_QUEUES - 1; q >= 0; q--)
        begin
            if (q < int'(active_n) && occ_reg[q] != '0)
            begin
                found  = 1'b1;
                prio_q = QW'(q);
            end
        end

        target = (req_reg == mfq_pkg::REQ_PRIO) ? prio_q : QW'(qidx_reg);
        occ_t  = occ_reg[target];
        head_t = head_reg[target];
        tail_t = tail_reg[target];

        do_push = (req_reg == mfq_pkg::REQ_ENQ) && valid_idx
                  && (occ_t != OW'(QUEUE_DEPTH));
        do_pop  = ((req_reg == mfq_pkg::REQ_DEQ) && valid_idx && (occ_t != '0))
                  || ((req_reg == mfq_pkg::REQ_PRIO) && found);

        if (req_reg == mfq_pkg::REQ_PRIO)
        begin
            status_c = found ? mfq_pkg::ST_OK : mfq_pkg::ST_EMPTY;
        end
        else if (!valid_idx)
        begin
            status_c = mfq_pkg::ST_BADIDX;
        end
        else if (req_reg == mfq_pkg::REQ_ENQ && !do_push)
        begin
            status_c = mfq_pkg::ST_FULL;
        end
        else if (req_reg == mfq_pkg::REQ_DEQ && !do_pop)
        begin
            status_c = mfq_pkg::ST_EMPTY;
        end
        else
        begin
            status_c = mfq_pkg::ST_OK;
        end

        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            occ_next[q] = occ_reg[q];
        end
        if (do_push)
        begin
            occ_next[target] = occ_t + OW'(1);
        end
        if (do_pop)
        begin
            occ_next[target] = occ_t - OW'(1);
        end

        if (req_reg == mfq_pkg::REQ_PRIO)
        begin
            qempty_c = found ? (occ_next[target] == '0) : 1'b1;
        end
        else
        begin
            qempty_c = valid_idx ? (occ_next[target] == '0) : 1'b1;
        end

        allempty_c = 1'b1;
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            if (q < int'(active_n) && occ_next[q] != '0)
            begin
                allempty_c = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                head_reg[q] <= '0;
                tail_reg[q] <= '0;
                occ_reg[q]  <= '0;
            end
        end
        else if (cmd.exec)
        begin
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                occ_reg[q] <= occ_next[q];
            end
            if (do_push)
            begin
                tail_reg[target] <= (tail_t == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_t + PW'(1);
            end
            if (do_pop)
            begin
                head_reg[target] <= (head_t == PW'(QUEUE_DEPTH - 1)) ? '0 : head_t + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && do_push)
        begin
            mem[{target, tail_t}] <= {pid_reg, time_reg};
        end
        if (cmd.exec)
        begin
            rdata_reg <= mem[{target, head_t}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg   <= status_c;
            served_reg   <= do_pop ? 2'(target) : 2'd0;
            qempty_reg   <= qempty_c;
            allempty_reg <= allempty_c;
            pop_reg      <= do_pop;
        end
    end

    assign status       = status_reg;
    assign out_pid      = pop_reg ? rdata_reg[31:16] : mfq_pkg::NO_PID;
    assign out_time     = $signed(pop_reg ? rdata_reg[15:0] : mfq_pkg::NO_TIME);
    assign served_queue = served_reg;
    assign queue_empty  = qempty_reg;
    assign all_empty    = allempty_reg;

endmodule

`default_nettype wire

// ----- src/multilevel_fifo_queue.sv -----
// Top level of the multilevel priority FIFO queue of process entries.
// Depends on mfq_pkg, mfq_ctrl and mfq_dp.
//
// Channel   Handshake                 Payload
// request   start / busy              req_type, queue_index, pid, exec_time
// result    done (one-cycle strobe)   status, out_pid, out_time, served_queue,
//                                     queue_empty, all_empty
// config    active_queues_we          active_queues
//
// A request first selects the queue, updates pointers and accesses the
// entry memory, then presents the result from the registered memory
// read. busy is high only in the first step; a new request is taken
// while the result is shown. Asynchronous active-low reset empties all
// queues and sets active_queues to 4. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module multilevel_fifo_queue #(
    parameter int NUM_QUEUES  = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         req_type,
    input  wire logic [1:0]         queue_index,
    input  wire logic [15:0]        pid,
    input  wire logic signed [15:0] exec_time,
    input  wire logic               active_queues_we,
    input  wire logic [2:0]         active_queues,
    output logic                    done,
    output logic [1:0]              status,
    output logic [15:0]             out_pid,
    output logic signed [15:0]      out_time,
    output logic [1:0]              served_queue,
    output logic                    queue_empty,
    output logic                    all_empty
);

    mfq_pkg::cmd_t cmd;

    mfq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    mfq_dp #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .req_type         (req_type),
        .queue_index      (queue_index),
        .pid              (pid),
        .exec_time        (exec_time),
        .active_queues_we (active_queues_we),
        .active_queues    (active_queues),
        .status           (status),
        .out_pid          (out_pid),
        .out_time         (out_time),
        .served_queue     (served_queue),
        .queue_empty      (queue_empty),
        .all_empty        (all_empty)
    );

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("request did not complete in two cycles");

    a_none_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != mfq_pkg::ST_OK |-> out_pid == 16'd0 && out_time == -16'sd1
            && served_queue == 2'd0)
        else $error("failed request carries entry data");
`endif

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for multilevel_fifo_queue: directed and random requests
// are checked against an in-bench prediction of the priority FIFO queues.
// Depends on mfq_pkg and the multilevel_fifo_queue RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int NQ    = 4;
    localparam int DEPTH = 16;
    localparam int LIMIT = 200000;
    localparam int PHASE_ITEMS = 94;

    typedef struct {
        mfq_pkg::status_t   status;
        logic [15:0]        pid;
        logic signed [15:0] tval;
        logic [1:0]         served;
        logic               qempty;
        logic               aempty;
    } outcome_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [1:0]         req_type = 2'd0;
    logic [1:0]         queue_index = 2'd0;
    logic [15:0]        pid = 16'd0;
    logic signed [15:0] exec_time = 16'sd0;
    logic               active_queues_we = 1'b0;
    logic [2:0]         active_queues = 3'd4;
    logic               busy;
    logic               done;
    logic [1:0]         status;
    logic [15:0]        out_pid;
    logic signed [15:0] out_time;
    logic [1:0]         served_queue;
    logic               queue_empty;
    logic               all_empty;

    logic [15:0]        slot_pid  [NQ][DEPTH];
    logic signed [15:0] slot_time [NQ][DEPTH];
    int                 head [NQ];
    int                 tail [NQ];
    int                 fill [NQ];
    int                 prio_span = 4;

    outcome_t           awaited_results[$];
    int                 errors = 0;
    int                 cycles = 0;
    bit                 gaps_on = 1'b1;

    always #5 clk = ~clk;

    multilevel_fifo_queue #(
        .NUM_QUEUES(NQ),
        .QUEUE_DEPTH(DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .queue_index(queue_index),
        .pid(pid),
        .exec_time(exec_time),
        .active_queues_we(active_queues_we),
        .active_queues(active_queues),
        .done(done),
        .status(status),
        .out_pid(out_pid),
        .out_time(out_time),
        .served_queue(served_queue),
        .queue_empty(queue_empty),
        .all_empty(all_empty)
    );

    function automatic logic active_all_empty();
        int n;
        n = (prio_span > NQ) ? NQ : prio_span;
        for (int q = 0; q < n; q++)
        begin
            if (fill[q] != 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void take_head(input int q, inout outcome_t o);
        o.pid     = slot_pid[q][head[q]];
        o.tval    = slot_time[q][head[q]];
        o.served  = q[1:0];
        head[q]   = (head[q] + 1) % DEPTH;
        fill[q]   = fill[q] - 1;
    endfunction

    function automatic outcome_t serve_request(mfq_pkg::req_t r, logic [1:0] qi,
                                               logic [15:0] p, logic signed [15:0] t);
        outcome_t o;
        int       n;
        int       q;
        o.status = mfq_pkg::ST_OK;
        o.pid    = mfq_pkg::NO_PID;
        o.tval   = mfq_pkg::NO_TIME;
        o.served = 2'd0;
        o.qempty = 1'b1;
        q        = qi;
        if (r == mfq_pkg::REQ_PRIO)
        begin
            n = (prio_span > NQ) ? NQ : prio_span;
            o.status = mfq_pkg::ST_EMPTY;
            for (int k = 0; k < n; k++)
            begin
                if (fill[k] != 0)
                begin
                    take_head(k, o);
                    o.status = mfq_pkg::ST_OK;
                    o.qempty = (fill[k] == 0);
                    break;
                end
            end
        end
        else if (q >= NQ)
        begin
            o.status = mfq_pkg::ST_BADIDX;
        end
        else
        begin
            if (r == mfq_pkg::REQ_ENQ)
            begin
                if (fill[q] >= DEPTH)
                    o.status = mfq_pkg::ST_FULL;
                else
                begin
                    slot_pid[q][tail[q]]  = p;
                    slot_time[q][tail[q]] = t;
                    tail[q] = (tail[q] + 1) % DEPTH;
                    fill[q] = fill[q] + 1;
                end
            end
            else if (r == mfq_pkg::REQ_DEQ)
            begin
                if (fill[q] == 0)
                    o.status = mfq_pkg::ST_EMPTY;
                else
                    take_head(q, o);
            end
            o.qempty = (fill[q] == 0);
        end
        o.aempty = active_all_empty();
        return o;
    endfunction

    task automatic send_request(mfq_pkg::req_t r, logic [1:0] qi, logic [15:0] p,
                                logic signed [15:0] t);
        req_type    <= r;
        queue_index <= qi;
        pid         <= p;
        exec_time   <= t;
        start       <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        awaited_results.push_back(serve_request(r, qi, p, t));
        if (gaps_on && $urandom_range(99) < 20)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_active_queues(int v);
        drain_results();
        active_queues    <= v[2:0];
        active_queues_we <= 1'b1;
        @(posedge clk);
        active_queues_we <= 1'b0;
        prio_span = v;
    endtask

    function automatic void check_field(string name, logic [15:0] exp, logic [15:0] act);
        if (exp !== act)
        begin
            $error("%s expected %0h got %0h", name, exp, act);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        outcome_t e;
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
            end
            else
            begin
                e = awaited_results.pop_front();
                check_field("status", 16'(e.status), 16'(status));
                check_field("out_pid", e.pid, out_pid);
                check_field("out_time", e.tval, out_time);
                check_field("served_queue", 16'(e.served), 16'(served_queue));
                check_field("queue_empty", 16'(e.qempty), 16'(queue_empty));
                check_field("all_empty", 16'(e.aempty), 16'(all_empty));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_empty_after_reset();
        for (int q = 0; q < NQ; q++)
            send_request(mfq_pkg::REQ_QRY, q[1:0], 16'h0000, 16'sd0);
        send_request(mfq_pkg::REQ_DEQ, 2'd2, 16'hFFFF, -16'sd1);
        send_request(mfq_pkg::REQ_PRIO, 2'd3, 16'h1234, 16'sd5);
    endtask

    task automatic test_field_extremes();
        send_request(mfq_pkg::REQ_ENQ, 2'd0, 16'hFFFF, 16'sd32767);
        send_request(mfq_pkg::REQ_ENQ, 2'd1, 16'h0000, -16'sd1);
        send_request(mfq_pkg::REQ_ENQ, 2'd2, 16'hA5A5, 16'sd0);
        send_request(mfq_pkg::REQ_ENQ, 2'd3, 16'h5A5A, 16'sd21845);
        send_request(mfq_pkg::REQ_QRY, 2'd3, 16'hFFFF, -16'sd1);
        send_request(mfq_pkg::REQ_PRIO, 2'd1, 16'h0000, 16'sd0);
        send_request(mfq_pkg::REQ_DEQ, 2'd3, 16'h0000, 16'sd0);
        send_request(mfq_pkg::REQ_DEQ, 2'd1, 16'h0000, 16'sd0);
        send_request(mfq_pkg::REQ_PRIO, 2'd0, 16'h0000, 16'sd0);
        send_request(mfq_pkg::REQ_PRIO, 2'd0, 16'h0000, 16'sd0);
    endtask

    task automatic test_active_count_limits();
        set_active_queues(0);
        send_request(mfq_pkg::REQ_ENQ, 2'd2, 16'h00FF, 16'sd100);
        send_request(mfq_pkg::REQ_PRIO, 2'd2, 16'h0000, 16'sd0);
        send_request(mfq_pkg::REQ_DEQ, 2'd2, 16'h0000, 16'sd0);
        set_active_queues(7);
        send_request(mfq_pkg::REQ_ENQ, 2'd3, 16'hFF00, 16'sd200);
        send_request(mfq_pkg::REQ_PRIO, 2'd0, 16'h0000, 16'sd0);
    endtask

    task automatic test_random_traffic(int span, int enq_pct, int focus, bit gaps);
        mfq_pkg::req_t      r;
        logic [1:0]         qi;
        logic [15:0]        p;
        logic signed [15:0] t;
        int                 pick;
        set_active_queues(span);
        gaps_on = gaps;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            pick = $urandom_range(99);
            if (pick < enq_pct)
                r = mfq_pkg::REQ_ENQ;
            else
            begin
                pick = $urandom_range(99);
                r = (pick < 40) ? mfq_pkg::REQ_DEQ
                    : (pick < 80) ? mfq_pkg::REQ_PRIO : mfq_pkg::REQ_QRY;
            end
            if (focus >= 0 && $urandom_range(99) < 70)
                qi = focus[1:0];
            else
                qi = 2'($urandom_range(NQ - 1));
            case ($urandom_range(9))
                0:       p = 16'h0000;
                1:       p = 16'hFFFF;
                default: p = 16'($urandom);
            endcase
            case ($urandom_range(9))
                0:       t = -16'sd1;
                1:       t = 16'sd32767;
                2:       t = 16'sd0;
                default: t = 16'($urandom_range(0, 32767));
            endcase
            send_request(r, qi, p, t);
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_after_reset();
        test_field_extremes();
        test_active_count_limits();
        test_random_traffic(1, 85, 1, 1'b1);
        test_random_traffic(4, 20, -1, 1'b1);
        test_random_traffic(2, 50, 0, 1'b1);
        test_random_traffic(0, 60, 3, 1'b1);
        test_random_traffic(5, 85, 2, 1'b0);
        test_random_traffic(3, 15, -1, 1'b1);
        test_random_traffic(6, 50, -1, 1'b1);
        test_random_traffic(4, 50, 0, 1'b1);
        drain_results();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- multilevel_fifo_queue.f -----
src/mfq_pkg.sv
src/mfq_ctrl.sv
src/mfq_dp.sv
src/multilevel_fifo_queue.sv
tb/testbench.sv
